@@ rtl/sspe_pkg.sv @@
// ============================================================================
// sspe_pkg: shared types and constants of the spline segment evaluator
// Number formats, coefficient and pipeline word types, register indexes
// and order codes used by the evaluator and its checker.
// ============================================================================
`default_nettype none

package sspe_pkg;

    // Fraction bits of positions and time (Q16.16 positions, Q2.16 time).
    localparam int FRAC_BITS = 16;

    // Fixed widths of the interface fields.
    localparam int POS_W   = 32;
    localparam int TIME_W  = 18;
    localparam int INDEX_W = 3;

    // Doubled polynomial coefficients stay below 2^40 in magnitude.
    localparam int COEF_W  = 41;
    // Horner accumulator, bounded by the sum of coefficient magnitudes.
    localparam int ACC_W   = 44;
    // Product of the accumulator and the nonnegative time.
    localparam int PROD_W  = ACC_W + TIME_W + 1;

    localparam int NUM_COEF  = 6;
    localparam int NUM_CELLS = NUM_COEF - 1;
    // Input register, one register per cell, output register.
    localparam int LATENCY   = NUM_CELLS + 2;

    // Time value that means one full segment.
    localparam logic [31:0] TIME_ONE = 32'(64'd1 << FRAC_BITS);

    // Rounding constant for the Horner step (ties toward plus infinity).
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (FRAC_BITS - 1));

    // Saturation limits of the result, at accumulator width.
    localparam logic signed [ACC_W-1:0] POS_MAX = ACC_W'(64'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] POS_MIN = -ACC_W'(64'sh8000_0000);

    localparam logic [POS_W-1:0] POS_MAX_WORD = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] POS_MIN_WORD = 32'h8000_0000;

    // Polynomial order codes; the remaining code three also selects the quintic.
    localparam logic [1:0] MODE_QUAD    = 2'd0;
    localparam logic [1:0] MODE_CUBIC   = 2'd1;
    localparam logic [1:0] MODE_QUINTIC = 2'd2;

    // Configuration register indexes.
    localparam logic [INDEX_W-1:0] REG_ORDER_MODE = 3'd0;
    localparam logic [INDEX_W-1:0] REG_START_POS  = 3'd1;
    localparam logic [INDEX_W-1:0] REG_START_VEL  = 3'd2;
    localparam logic [INDEX_W-1:0] REG_START_ACC  = 3'd3;
    localparam logic [INDEX_W-1:0] REG_END_POS    = 3'd4;
    localparam logic [INDEX_W-1:0] REG_END_VEL    = 3'd5;
    localparam logic [INDEX_W-1:0] REG_END_ACC    = 3'd6;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [TIME_W-1:0]        time_t;

    // Word handed from one Horner cell to the next.
    typedef struct packed {
        logic  valid;
        time_t t;
        acc_t  acc;
    } stage_t;

endpackage

`default_nettype wire

@@ rtl/sspe_coef.sv @@
// ============================================================================
// sspe_coef: boundary condition registers and coefficient generator
// Holds the segment registers and forms the six doubled polynomial
// coefficients from them, registered for the Horner cells.
// ============================================================================
`default_nettype none

module sspe_coef (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              wr_en,
    input  wire logic [sspe_pkg::INDEX_W-1:0]      wr_index,
    input  wire logic [sspe_pkg::POS_W-1:0]        wr_data,
    output sspe_pkg::coef_t                        coef [sspe_pkg::NUM_COEF]
);

    logic [1:0]                        order_mode_reg;
    logic signed [sspe_pkg::POS_W-1:0] start_pos_reg;
    logic signed [sspe_pkg::POS_W-1:0] start_vel_reg;
    logic signed [sspe_pkg::POS_W-1:0] start_acc_reg;
    logic signed [sspe_pkg::POS_W-1:0] end_pos_reg;
    logic signed [sspe_pkg::POS_W-1:0] end_vel_reg;
    logic signed [sspe_pkg::POS_W-1:0] end_acc_reg;

    sspe_pkg::coef_t coef_reg  [sspe_pkg::NUM_COEF];
    sspe_pkg::coef_t coef_next [sspe_pkg::NUM_COEF];

    sspe_pkg::coef_t sp, sv, sa, ep, ev, ea;
    sspe_pkg::coef_t dx, y1x2, y2, y3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_mode_reg <= sspe_pkg::MODE_QUINTIC;
            start_pos_reg  <= '0;
            start_vel_reg  <= '0;
            start_acc_reg  <= '0;
            end_pos_reg    <= '0;
            end_vel_reg    <= '0;
            end_acc_reg    <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                sspe_pkg::REG_ORDER_MODE: order_mode_reg <= wr_data[1:0];
                sspe_pkg::REG_START_POS:  start_pos_reg  <= wr_data;
                sspe_pkg::REG_START_VEL:  start_vel_reg  <= wr_data;
                sspe_pkg::REG_START_ACC:  start_acc_reg  <= wr_data;
                sspe_pkg::REG_END_POS:    end_pos_reg    <= wr_data;
                sspe_pkg::REG_END_VEL:    end_vel_reg    <= wr_data;
                sspe_pkg::REG_END_ACC:    end_acc_reg    <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    // Coefficients are kept at twice their value so every weight is integral.
    always_comb
    begin
        sp = sspe_pkg::COEF_W'(start_pos_reg);
        sv = sspe_pkg::COEF_W'(start_vel_reg);
        sa = sspe_pkg::COEF_W'(start_acc_reg);
        ep = sspe_pkg::COEF_W'(end_pos_reg);
        ev = sspe_pkg::COEF_W'(end_vel_reg);
        ea = sspe_pkg::COEF_W'(end_acc_reg);

        dx   = ep - sp;
        y1x2 = (ep <<< 1) - sa - (sv <<< 1) - (sp <<< 1);
        y2   = ev - sa - sv;
        y3   = ea - sa;

        coef_next[0] = '0;
        coef_next[1] = '0;
        coef_next[2] = '0;
        coef_next[3] = '0;
        coef_next[4] = sv <<< 1;
        coef_next[5] = sp <<< 1;

        unique case (order_mode_reg)
            sspe_pkg::MODE_QUAD:
            begin
                coef_next[3] = (ep - sp - sv) <<< 1;
            end
            sspe_pkg::MODE_CUBIC:
            begin
                coef_next[2] = (ev + sv - (dx <<< 1)) <<< 1;
                coef_next[3] = ((dx <<< 1) + dx - (sv <<< 1) - ev) <<< 1;
            end
            default:
            begin
                coef_next[0] = sspe_pkg::coef_t'(6) * y1x2 - sspe_pkg::coef_t'(6) * y2 + y3;
                coef_next[1] = sspe_pkg::coef_t'(14) * y2 - sspe_pkg::coef_t'(15) * y1x2
                               - (y3 <<< 1);
                coef_next[2] = sspe_pkg::coef_t'(10) * y1x2 - (y2 <<< 3) + y3;
                coef_next[3] = sa;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sspe_pkg::NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < sspe_pkg::NUM_COEF; i++)
            begin
                coef_reg[i] <= coef_next[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < sspe_pkg::NUM_COEF; i++)
        begin
            coef[i] = coef_reg[i];
        end
    end

endmodule

`default_nettype wire

@@ rtl/sspe_cell.sv @@
// ============================================================================
// sspe_cell: one Horner step of the polynomial chain
// Multiplies the incoming accumulator by time, rounds, adds its own
// coefficient and registers the word for the next cell.
// ============================================================================
`default_nettype none

module sspe_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sspe_pkg::stage_t stage_in,
    input  wire sspe_pkg::coef_t  coef,
    output sspe_pkg::stage_t     stage_out
);

    logic                             valid_reg;
    sspe_pkg::time_t                  t_reg;
    sspe_pkg::acc_t                   acc_reg;
    sspe_pkg::acc_t                   acc_next;

    logic signed [sspe_pkg::PROD_W-1:0] prod;
    logic signed [sspe_pkg::PROD_W-1:0] prod_rnd;
    logic signed [sspe_pkg::PROD_W-1:0] prod_scaled;

    // Time is never negative here, so it enters the product with a zero sign bit.
    always_comb
    begin
        prod        = stage_in.acc * $signed({1'b0, stage_in.t});
        prod_rnd    = prod + sspe_pkg::ROUND_HALF;
        prod_scaled = prod_rnd >>> sspe_pkg::FRAC_BITS;
        acc_next    = prod_scaled[sspe_pkg::ACC_W-1:0] + sspe_pkg::ACC_W'(coef);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg   <= stage_in.t;
        acc_reg <= acc_next;
    end

    assign stage_out = '{valid: valid_reg, t: t_reg, acc: acc_reg};

endmodule

`default_nettype wire

@@ rtl/spline_segment_position_eval_unit.sv @@
// ============================================================================
// spline_segment_position_eval_unit: trajectory spline segment evaluator
// Evaluates the position of a quadratic, cubic or quintic segment at a
// stream of normalized times, with a saturated Q16.16 result.
// ============================================================================
// The unit takes one time word in every clock cycle and never holds the
// sender off: busy is always low, so a word is taken whenever start is high.
// Each result appears on position and saturated for one cycle, marked by
// done. The time is clamped and registered, passes through the five Horner
// cells, and is halved, rounded and saturated into the output register.
// Results leave in the order the time words came in, and the receiver must
// take each word in its cycle. Write the boundary conditions and order
// through wr_en, wr_index and wr_data only while no result is outstanding.
// The coefficient registers are loaded from the boundary registers, which
// is early enough for a time word started on the cycle after the write.
// A write to index seven is dropped. Negative times evaluate as time zero
// and times beyond one as time one.
// ============================================================================
`default_nettype none

module spline_segment_position_eval_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Time words
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic signed [sspe_pkg::TIME_W-1:0]    time_frac,
    // Result words
    output logic                                       done,
    output logic signed [sspe_pkg::POS_W-1:0]          position,
    output logic                                       saturated,
    // Configuration writes
    input  wire logic                                  wr_en,
    input  wire logic [sspe_pkg::INDEX_W-1:0]          wr_index,
    input  wire logic [sspe_pkg::POS_W-1:0]            wr_data
);

    sspe_pkg::coef_t  coef [sspe_pkg::NUM_COEF];
    sspe_pkg::stage_t stage [sspe_pkg::NUM_CELLS + 1];

    logic            in_valid_reg;
    sspe_pkg::time_t in_t_reg;
    sspe_pkg::time_t t_clamped;

    sspe_pkg::acc_t  acc_plus;
    sspe_pkg::acc_t  acc_half;
    logic            done_reg;
    logic signed [sspe_pkg::POS_W-1:0] position_reg;
    logic signed [sspe_pkg::POS_W-1:0] position_next;
    logic            saturated_reg;
    logic            saturated_next;

    // The pipeline has no stall point, so the unit is always ready.
    assign busy = 1'b0;

    // Boundary condition registers and coefficient generation.
    sspe_coef u_coef (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .coef     (coef)
    );

    // Clamp the time into 0..one; the upper clamp fires for words above one.
    always_comb
    begin
        priority if (time_frac[sspe_pkg::TIME_W-1])
        begin
            t_clamped = '0;
        end
        else if (32'(time_frac) > sspe_pkg::TIME_ONE)
        begin
            t_clamped = sspe_pkg::TIME_W'(sspe_pkg::TIME_ONE);
        end
        else
        begin
            t_clamped = time_frac;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        in_t_reg <= t_clamped;
    end

    // The first cell starts Horner's rule from the highest coefficient.
    assign stage[0] = '{valid: in_valid_reg, t: in_t_reg, acc: sspe_pkg::ACC_W'(coef[0])};

    // Chain of Horner cells; cell k folds in coefficient k+1.
    for (genvar k = 0; k < sspe_pkg::NUM_CELLS; k++)
    begin : g_cell
        sspe_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (stage[k]),
            .coef      (coef[k + 1]),
            .stage_out (stage[k + 1])
        );
    end

    // The accumulator holds twice the position: halve with ties upward,
    // then clamp to the 32-bit range.
    always_comb
    begin
        acc_plus = stage[sspe_pkg::NUM_CELLS].acc + sspe_pkg::ACC_W'(1);
        acc_half = acc_plus >>> 1;
        priority if (acc_half > sspe_pkg::POS_MAX)
        begin
            position_next  = sspe_pkg::POS_MAX_WORD;
            saturated_next = 1'b1;
        end
        else if (acc_half < sspe_pkg::POS_MIN)
        begin
            position_next  = sspe_pkg::POS_MIN_WORD;
            saturated_next = 1'b1;
        end
        else
        begin
            position_next  = acc_half[sspe_pkg::POS_W-1:0];
            saturated_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage[sspe_pkg::NUM_CELLS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        position_reg  <= position_next;
        saturated_reg <= saturated_next;
    end

    assign done      = done_reg;
    assign position  = position_reg;
    assign saturated = saturated_reg;

endmodule

`default_nettype wire

@@ rtl/sspe_chk.sv @@
// ============================================================================
// sspe_chk: port checker for the spline segment evaluator
// Watches the top-level ports for fixed latency, a busy that stays low and
// a consistent saturation flag; bound to every instance of the top level.
// ============================================================================
`default_nettype none

module sspe_chk (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic                                  busy,
    input  wire logic                                  done,
    input  wire logic signed [sspe_pkg::POS_W-1:0]     position,
    input  wire logic                                  saturated
);

    // Every accepted time word gives a result after the fixed latency.
    a_latency_fwd : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(sspe_pkg::LATENCY) done)
        else $error("accepted word produced no result at the fixed latency");

    // No result appears without a word accepted at the fixed latency before.
    a_latency_back : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, sspe_pkg::LATENCY))
        else $error("result word without a matching accepted word");

    // A saturated result sits exactly at one of the two limits.
    a_sat_limit : assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |->
            (position == sspe_pkg::POS_MAX_WORD || position == sspe_pkg::POS_MIN_WORD))
        else $error("saturation flag set on a value inside the range");

    // The unit never refuses a word.
    a_never_busy : assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised although the pipeline cannot stall");

endmodule

bind spline_segment_position_eval_unit sspe_chk u_sspe_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .position  (position),
    .saturated (saturated)
);

`default_nettype wire

@@ verif/spline_segment_position_eval_unit_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// spline_segment_position_eval_unit_tb: self-checking bench of the evaluator
// Loads segment boundary conditions through the write port, streams time
// words, and compares each result with a Horner-rule predictor or a typed row.
// ============================================================================

module spline_segment_position_eval_unit_tb;

    import sspe_pkg::*;

    // Index seven has no register behind it; writes there must be dropped.
    localparam logic [INDEX_W-1:0] REG_UNUSED = 3'd7;

    // Sender idle chances, in percent per cycle, for the three traffic phases.
    // The receiver cannot hold results off, so only the sender side idles.
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_HEAVY = 79;
    localparam int IDLE_LIGHT = 6;

    localparam int NUM_SEGMENTS      = 27;
    localparam int WORDS_PER_SEGMENT = 50;

    // One line of the directed stimulus table.
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_EVAL,
        ROW_EVAL_TYPED
    } row_kind_e;

    typedef struct {
        row_kind_e                 kind;
        logic [INDEX_W-1:0]        index;
        logic [POS_W-1:0]          data;
        logic signed [TIME_W-1:0]  t;
        logic [POS_W-1:0]          want_position;
        logic                      want_saturated;
    } stim_row_t;

    // One result word as the block presents it.
    typedef struct {
        logic [POS_W-1:0] position;
        logic             saturated;
    } position_word_t;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic signed [TIME_W-1:0]   time_frac = '0;
    logic                       wr_en = 1'b0;
    logic [INDEX_W-1:0]         wr_index = '0;
    logic [POS_W-1:0]           wr_data = '0;
    wire                        busy;
    wire                        done;
    wire signed [POS_W-1:0]     position;
    wire                        saturated;

    // Expected word riding along with start, used by the typed table rows.
    logic                       typed_word = 1'b0;
    logic [POS_W-1:0]           typed_position = '0;
    logic                       typed_saturated = 1'b0;

    // Shadow copy of the boundary condition registers, at reset values.
    logic [1:0]                 seg_mode = MODE_QUINTIC;
    longint                     seg_start_pos = 0;
    longint                     seg_start_vel = 0;
    longint                     seg_start_acc = 0;
    longint                     seg_end_pos = 0;
    longint                     seg_end_vel = 0;
    longint                     seg_end_acc = 0;

    position_word_t             pending_positions[$];
    stim_row_t                  directed_rows[$];
    int                         mismatch_count = 0;
    int                         send_idle_pct = IDLE_NONE;

    spline_segment_position_eval_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .time_frac (time_frac),
        .done      (done),
        .position  (position),
        .saturated (saturated),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Mirrors a register write into the shadow copy. Registers are signed
    // Q16.16 words; only the two low bits of the order word matter.
    function automatic void shadow_write(input logic [INDEX_W-1:0] idx,
                                         input logic [POS_W-1:0] value);
        case (idx)
            REG_ORDER_MODE: seg_mode      = value[1:0];
            REG_START_POS:  seg_start_pos = longint'($signed(value));
            REG_START_VEL:  seg_start_vel = longint'($signed(value));
            REG_START_ACC:  seg_start_acc = longint'($signed(value));
            REG_END_POS:    seg_end_pos   = longint'($signed(value));
            REG_END_VEL:    seg_end_vel   = longint'($signed(value));
            REG_END_ACC:    seg_end_acc   = longint'($signed(value));
            default: ;
        endcase
    endfunction

    // Position of the current segment at one time word. All coefficients are
    // kept at twice their value so the halves in the quintic stay exact, and
    // the final halving rounds ties toward plus infinity.
    function automatic position_word_t eval_segment_position(
        input logic signed [TIME_W-1:0] t_in);
        position_word_t result;
        longint         one_t;
        longint         half_lsb;
        longint         t;
        longint         dx;
        longint         y1x2;
        longint         y2;
        longint         y3;
        longint         acc;
        longint         pos;
        longint         c[NUM_COEF];
        int             k;

        one_t    = longint'(1) << FRAC_BITS;
        half_lsb = longint'(1) << (FRAC_BITS - 1);
        t        = t_in;
        if (t < 0)
            t = 0;
        else if (t > one_t)
            t = one_t;

        for (k = 0; k < NUM_COEF; k++)
            c[k] = 0;
        dx = seg_end_pos - seg_start_pos;
        case (seg_mode)
            MODE_QUAD:
            begin
                c[3] = 2 * (dx - seg_start_vel);
            end
            MODE_CUBIC:
            begin
                c[2] = 2 * (seg_end_vel + seg_start_vel - 2 * dx);
                c[3] = 2 * (3 * dx - 2 * seg_start_vel - seg_end_vel);
            end
            default:
            begin
                y1x2 = 2 * seg_end_pos - seg_start_acc - 2 * seg_start_vel
                       - 2 * seg_start_pos;
                y2   = seg_end_vel - seg_start_acc - seg_start_vel;
                y3   = seg_end_acc - seg_start_acc;
                c[0] = 6 * y1x2 - 6 * y2 + y3;
                c[1] = -15 * y1x2 + 14 * y2 - 2 * y3;
                c[2] = 10 * y1x2 - 8 * y2 + y3;
                c[3] = seg_start_acc;
            end
        endcase
        c[4] = 2 * seg_start_vel;
        c[5] = 2 * seg_start_pos;

        // Horner's rule; an arithmetic shift of a longint is a floor.
        acc = c[0];
        for (k = 1; k < NUM_COEF; k++)
            acc = ((acc * t + half_lsb) >>> FRAC_BITS) + c[k];
        pos = (acc + 1) >>> 1;

        result.saturated = 1'b1;
        if (pos > 64'sd2147483647)
            result.position = POS_MAX_WORD;
        else if (pos < -64'sd2147483648)
            result.position = POS_MIN_WORD;
        else
        begin
            result.position  = pos[POS_W-1:0];
            result.saturated = 1'b0;
        end
        return result;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------------

    // Everything is sampled at the rising edge, before the edge's own updates
    // land, so a word counts as taken when start was high and busy low.
    // Results are checked before new expectations are queued so that a stray
    // done can never pair with a word that was taken in the same cycle.
    always @(posedge clk)
    begin
        position_word_t want;

        if (rst_n)
        begin
            if (done)
            begin
                if (pending_positions.size() == 0)
                begin
                    $error("unexpected result word: position %0d saturated %0b",
                           position, saturated);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_positions.pop_front();
                    if (position !== want.position)
                    begin
                        $error("position mismatch: expected %0d, actual %0d",
                               $signed(want.position), position);
                        mismatch_count++;
                    end
                    if (saturated !== want.saturated)
                    begin
                        $error("saturated mismatch: expected %0b, actual %0b",
                               want.saturated, saturated);
                        mismatch_count++;
                    end
                end
            end

            if (wr_en)
                shadow_write(wr_index, wr_data);

            if (start && !busy)
            begin
                if (typed_word)
                begin
                    want.position  = typed_position;
                    want.saturated = typed_saturated;
                end
                else
                    want = eval_segment_position(time_frac);
                pending_positions.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Presents one register write; the caller lowers wr_en after the last
    // write of a batch so that wr_en never gets two updates in one step.
    task automatic write_reg(input logic [INDEX_W-1:0] idx,
                             input logic [POS_W-1:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
    endtask

    // Sends one time word after a random number of idle cycles and returns
    // at the edge that takes it. Start stays high for a back-to-back word.
    task automatic send_time(input logic signed [TIME_W-1:0] t,
                             input logic typed,
                             input logic [POS_W-1:0] want_position,
                             input logic want_saturated);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start           <= 1'b1;
        time_frac       <= t;
        typed_word      <= typed;
        typed_position  <= want_position;
        typed_saturated <= want_saturated;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stops sending, waits for every outstanding result, then lets the
    // pipeline run empty for its full depth so the block is idle.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_positions.size() != 0)
            @(posedge clk);
        repeat (LATENCY)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Random stimulus helpers
    // ------------------------------------------------------------------------

    // Boundary values lean toward the extremes and toward small numbers,
    // since those are the ones that reach and miss saturation.
    function automatic logic [POS_W-1:0] pick_boundary_value();
        case ($urandom_range(15))
            0, 1:       return POS_MAX_WORD;
            2, 3:       return POS_MIN_WORD;
            4:          return '0;
            5, 6, 7, 8: return POS_W'($urandom_range(32'h0010_0000)) - 32'h0008_0000;
            default:    return $urandom;
        endcase
    endfunction

    // Time words cover negative values, values beyond one, both ends exactly,
    // and mostly the inside of the segment.
    function automatic logic signed [TIME_W-1:0] pick_time();
        logic signed [TIME_W-1:0] t;

        case ($urandom_range(15))
            0, 1:    t = {1'b1, (TIME_W - 1)'($urandom)};
            2, 3:    t = TIME_W'($urandom_range(131071, TIME_ONE + 1));
            4:       t = '0;
            5:       t = TIME_W'(TIME_ONE);
            default: t = TIME_W'($urandom_range(TIME_ONE));
        endcase
        return t;
    endfunction

    // Directed table builders.
    function automatic void add_write(input logic [INDEX_W-1:0] idx,
                                      input logic [POS_W-1:0] value);
        directed_rows.push_back('{ROW_WRITE, idx, value, '0, '0, 1'b0});
    endfunction

    function automatic void add_eval(input logic signed [TIME_W-1:0] t);
        directed_rows.push_back('{ROW_EVAL, REG_ORDER_MODE, '0, t, '0, 1'b0});
    endfunction

    function automatic void add_typed(input logic signed [TIME_W-1:0] t,
                                      input logic [POS_W-1:0] want_position,
                                      input logic want_saturated);
        directed_rows.push_back('{ROW_EVAL_TYPED, REG_ORDER_MODE, '0, t,
                                  want_position, want_saturated});
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        logic             writing;
        logic [POS_W-1:0] mode_word;
        int               seg;
        int               n;
        int               pause_at;

        // After reset every boundary condition is zero, so every time gives zero.
        add_typed(18'sd0, '0, 1'b0);
        add_typed(-18'sd131072, '0, 1'b0);
        add_typed(18'sd131071, '0, 1'b0);
        add_typed(18'sd32768, '0, 1'b0);
        add_typed(18'sd1, '0, 1'b0);

        // Quadratic that overshoots the top: mid-segment saturates, while
        // the ends give the boundary positions exactly.
        add_write(REG_ORDER_MODE, 32'(MODE_QUAD));
        add_write(REG_START_POS, POS_MAX_WORD);
        add_write(REG_START_VEL, POS_MAX_WORD);
        add_write(REG_END_POS, POS_MAX_WORD);
        add_typed(18'sd32768, POS_MAX_WORD, 1'b1);
        add_typed(18'sd0, POS_MAX_WORD, 1'b0);
        add_typed(18'sd65536, POS_MAX_WORD, 1'b0);
        add_typed(-18'sd5, POS_MAX_WORD, 1'b0);

        // The same shape below the bottom.
        add_write(REG_START_POS, POS_MIN_WORD);
        add_write(REG_START_VEL, POS_MIN_WORD);
        add_write(REG_END_POS, POS_MIN_WORD);
        add_typed(18'sd32768, POS_MIN_WORD, 1'b1);
        add_typed(18'sd131071, POS_MIN_WORD, 1'b0);

        // Cubic from -2.0 to 3.0 with end velocities; times past either end
        // are clamped onto the boundary positions.
        add_write(REG_ORDER_MODE, 32'(MODE_CUBIC));
        add_write(REG_START_POS, 32'hFFFE_0000);
        add_write(REG_START_VEL, 32'h0001_8000);
        add_write(REG_END_VEL, 32'hFFFF_0000);
        add_write(REG_END_POS, 32'h0003_0000);
        add_eval(18'sd16384);
        add_eval(18'sd65535);
        add_typed(18'sd70000, 32'h0003_0000, 1'b0);
        add_typed(-18'sd1, 32'hFFFE_0000, 1'b0);

        // Order code three, with junk in the upper bits, acts as a quintic.
        add_write(REG_ORDER_MODE, 32'hFFFF_FFFF);
        add_write(REG_START_ACC, 32'h0002_0000);
        add_write(REG_END_ACC, 32'hFFFC_0000);
        add_write(REG_END_VEL, 32'h0000_4000);
        add_eval(18'sd1);
        add_eval(18'sd49152);
        add_typed(18'sd65536, 32'h0003_0000, 1'b0);

        // A write to the unused index must leave the segment alone.
        add_write(REG_UNUSED, 32'hDEAD_BEEF);
        add_eval(18'sd20000);

        // Point-to-point quintic: zero rates, from 0.0 to 10.0.
        add_write(REG_ORDER_MODE, 32'(MODE_QUINTIC));
        add_write(REG_START_POS, '0);
        add_write(REG_START_VEL, '0);
        add_write(REG_START_ACC, '0);
        add_write(REG_END_VEL, '0);
        add_write(REG_END_ACC, '0);
        add_write(REG_END_POS, 32'h000A_0000);
        add_eval(18'sd32768);
        add_eval(18'sd6554);

        // Quintic with opposing extreme rates, for the widest coefficients.
        add_write(REG_START_POS, POS_MIN_WORD);
        add_write(REG_START_VEL, POS_MAX_WORD);
        add_write(REG_START_ACC, POS_MAX_WORD);
        add_write(REG_END_POS, POS_MAX_WORD);
        add_write(REG_END_VEL, POS_MIN_WORD);
        add_write(REG_END_ACC, POS_MIN_WORD);
        add_eval(18'sd32768);
        add_eval(18'sd13107);

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. A run of writes is only started once the block
        // has gone idle, and wr_en drops on the first word after the run.
        writing = 1'b0;
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_WRITE)
            begin
                if (!writing)
                    drain_results();
                write_reg(directed_rows[r].index, directed_rows[r].data);
                writing = 1'b1;
            end
            else
            begin
                if (writing)
                    wr_en <= 1'b0;
                writing = 1'b0;
                send_time(directed_rows[r].t, directed_rows[r].kind == ROW_EVAL_TYPED,
                          directed_rows[r].want_position,
                          directed_rows[r].want_saturated);
            end
        end

        // Random segments. Each one loads a fresh set of boundary
        // conditions while idle, then streams time words in one of the
        // traffic phases. Once per segment the sender also stops mid-stream
        // until every outstanding result is back.
        for (seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            drain_results();
            // Any of the four order codes, sometimes with upper bits set.
            mode_word      = $urandom_range(1) ? $urandom : 32'd0;
            mode_word[1:0] = 2'($urandom_range(3));
            write_reg(REG_ORDER_MODE, mode_word);
            write_reg(REG_START_POS, pick_boundary_value());
            write_reg(REG_START_VEL, pick_boundary_value());
            write_reg(REG_START_ACC, pick_boundary_value());
            write_reg(REG_END_POS, pick_boundary_value());
            write_reg(REG_END_VEL, pick_boundary_value());
            write_reg(REG_END_ACC, pick_boundary_value());
            if ($urandom_range(3) == 0)
                write_reg(REG_UNUSED, $urandom);
            wr_en <= 1'b0;

            case (seg % 3)
                0:       send_idle_pct = IDLE_NONE;
                1:       send_idle_pct = IDLE_HEAVY;
                default: send_idle_pct = IDLE_LIGHT;
            endcase

            pause_at = $urandom_range(WORDS_PER_SEGMENT - 1);
            for (n = 0; n < WORDS_PER_SEGMENT; n++)
            begin
                if (n == pause_at)
                    drain_results();
                send_time(pick_time(), 1'b0, '0, 1'b0);
            end
        end

        // Wait out the last results and a full pipeline depth beyond, so a
        // late stray word would still be caught.
        drain_results();
        repeat (LATENCY)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS spline_segment_position_eval_unit");
        else
            $display("FAIL spline_segment_position_eval_unit");
        $finish;
    end

    // Watchdog: the slowest correct run needs well under a tenth of this.
    initial
    begin
        #2_000_000;
        $display("FAIL spline_segment_position_eval_unit");
        $finish;
    end

endmodule
